>>> rtl/lprc_pkg.sv
// ----------------------------------------------------------------------------
// lprc_pkg
// Types and constants for the link packet reassembly control block.
// ----------------------------------------------------------------------------
package lprc_pkg;

    localparam int HB_DUMMY_BIT = 9;
    localparam int HB_FIRST_BIT = 8;
    localparam int HB_VALID_BIT = 7;
    localparam int HB_TYPE_BIT  = 6;
    localparam int HB_COUNT_MSB = 5;

    localparam logic [7:0]  VER_FIRST_BIT = 8'd1;
    localparam logic [7:0]  VER_DUMMY_BIT = 8'd2;
    localparam logic [16:0] FILL_MAX      = 17'h1FFFF;
    localparam logic [16:0] PAYLOAD_RESET = 17'd32;

    localparam logic [1:0] CFG_VERSION = 2'd0;
    localparam logic [1:0] CFG_ACK_EN  = 2'd1;
    localparam logic [1:0] CFG_PAYLOAD = 2'd2;

    typedef enum logic [1:0] {
        ACK_REQUIRED = 2'd0,
        ACK_SKIP     = 2'd1,
        ACK_FAULT    = 2'd2
    } ack_t;

    typedef enum logic [1:0] {
        ACT_NONE        = 2'd0,
        ACT_APPEND      = 2'd1,
        ACT_DELIVER_DG  = 2'd2,
        ACT_DELIVER_PKT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        EV_OK       = 3'd0,
        EV_CRC      = 3'd1,
        EV_GARBAGE  = 3'd2,
        EV_NO_FIRST = 3'd3,
        EV_RESTART  = 3'd4,
        EV_STRAY    = 3'd5,
        EV_SEQUENCE = 3'd6,
        EV_OVERFLOW = 3'd7
    } event_t;

    typedef struct packed {
        logic [7:0]  version;
        logic        ack_en;
        logic [16:0] payload;
    } cfg_t;

    typedef struct packed {
        logic [16:0] fill;
        logic [7:0]  pkts;
    } state_t;

    typedef struct packed {
        ack_t        ack;
        action_t     act;
        logic [15:0] offset;
        logic [16:0] length;
        logic        link;
        event_t      ev;
    } result_t;

endpackage

>>> rtl/lprc_decide.sv
// ----------------------------------------------------------------------------
// lprc_decide
// Per-packet decision: acknowledge class, buffer action and next reassembly
// state from one header, the CRC flag, configuration and current state.
// ----------------------------------------------------------------------------
module lprc_decide #(
    parameter int MAX_DATAGRAM_BYTES = 2048
) (
    input  logic [15:0]      header,
    input  logic             crc,
    input  lprc_pkg::cfg_t   cfg,
    input  lprc_pkg::state_t cur,
    output lprc_pkg::state_t nxt,
    output lprc_pkg::result_t res
);

    localparam logic [16:0] MAX_BYTES = 17'(MAX_DATAGRAM_BYTES);

    logic [7:0]  cnt;
    logic [16:0] fill_v;
    logic [7:0]  pkts_v;
    logic [7:0]  pkts_dec;
    logic [17:0] sum;
    logic [16:0] sum_sat;
    logic        stop;
    logic [1:0]  sel;

    assign cnt      = {2'b00, header[lprc_pkg::HB_COUNT_MSB:0]};
    assign pkts_dec = cur.pkts - 8'd1;
    assign sel      = {header[lprc_pkg::HB_DUMMY_BIT], header[lprc_pkg::HB_VALID_BIT]};
    assign sum      = {1'b0, cur.fill} + {1'b0, cfg.payload};
    assign sum_sat  = sum[17] ? lprc_pkg::FILL_MAX : sum[16:0];

    always_comb
    begin
        res.ack    = lprc_pkg::ACK_REQUIRED;
        res.act    = lprc_pkg::ACT_NONE;
        res.offset = '0;
        res.length = '0;
        res.link   = 1'b0;
        res.ev     = lprc_pkg::EV_OK;
        nxt        = cur;
        fill_v     = cur.fill;
        pkts_v     = cur.pkts;
        stop       = 1'b0;

        if (!crc)
        begin
            res.ack = lprc_pkg::ACK_FAULT;
            res.ev  = lprc_pkg::EV_CRC;
            if (!cfg.ack_en)
            begin
                nxt = '0;
            end
        end
        else if (cfg.version >= lprc_pkg::VER_DUMMY_BIT && sel == 2'b10)
        begin
            res.ack = lprc_pkg::ACK_SKIP;
        end
        else if (cfg.version >= lprc_pkg::VER_DUMMY_BIT && sel != 2'b01)
        begin
            res.ack = lprc_pkg::ACK_FAULT;
            res.ev  = lprc_pkg::EV_GARBAGE;
        end
        else if (cfg.version < lprc_pkg::VER_DUMMY_BIT && !header[lprc_pkg::HB_VALID_BIT])
        begin
            res.ack = lprc_pkg::ACK_SKIP;
        end
        else
        begin
            res.link = ~header[lprc_pkg::HB_TYPE_BIT];
            if (cfg.payload == MAX_BYTES)
            begin
                if (cfg.version < lprc_pkg::VER_FIRST_BIT || header[lprc_pkg::HB_FIRST_BIT])
                begin
                    res.act    = lprc_pkg::ACT_DELIVER_PKT;
                    res.length = cfg.payload;
                end
                else
                begin
                    res.ev = lprc_pkg::EV_NO_FIRST;
                end
            end
            else
            begin
                if (cfg.version >= lprc_pkg::VER_FIRST_BIT)
                begin
                    if (header[lprc_pkg::HB_FIRST_BIT])
                    begin
                        if (cur.fill != '0)
                        begin
                            res.ev = lprc_pkg::EV_RESTART;
                            fill_v = '0;
                        end
                        pkts_v = cnt;
                    end
                    else if (cur.fill == '0)
                    begin
                        res.ev = lprc_pkg::EV_STRAY;
                        stop   = 1'b1;
                    end
                    else if (cnt != pkts_dec)
                    begin
                        res.ev = lprc_pkg::EV_SEQUENCE;
                        fill_v = '0;
                        pkts_v = '0;
                        stop   = 1'b1;
                    end
                    else
                    begin
                        pkts_v = pkts_dec;
                    end
                end

                if (!stop)
                begin
                    if (fill_v >= MAX_BYTES)
                    begin
                        res.ev = lprc_pkg::EV_OVERFLOW;
                        fill_v = '0;
                    end
                    else if (cnt != '0)
                    begin
                        res.act    = lprc_pkg::ACT_APPEND;
                        res.offset = fill_v[15:0];
                        fill_v     = (fill_v == cur.fill) ? sum_sat
                                   : cfg.payload;
                    end
                    else
                    begin
                        res.act    = lprc_pkg::ACT_DELIVER_DG;
                        res.offset = fill_v[15:0];
                        res.length = (fill_v == cur.fill) ? sum_sat
                                   : cfg.payload;
                        fill_v     = '0;
                    end
                end
                nxt.fill = fill_v;
                nxt.pkts = pkts_v;
            end
        end
    end

endmodule

>>> rtl/link_packet_reassembly_control.sv
// ----------------------------------------------------------------------------
// link_packet_reassembly_control
// Decides acknowledge, append and deliver for each received link packet and
// tracks the datagram reassembly offset and the remaining-packet count.
// ----------------------------------------------------------------------------
// channel   handshake                 payload
// in        in_valid / in_stall       header_word, crc_ok
// out       out_valid / out_stall     ack_code, action, write_offset,
//                                     deliver_length, to_link_layer, event_code
// cfg       cfg_we                    cfg_index, cfg_data
//
// One packet per cycle sustained while out_stall is low; input register, then
// decode into the result register, where the reassembly state also updates.
// Reset clears pipeline valids and the reassembly state and loads the
// register defaults. A stalled result holds the result register and, through
// it, the input register; in_stall rises only when both are occupied.
// ----------------------------------------------------------------------------
module link_packet_reassembly_control #(
    parameter int MAX_DATAGRAM_BYTES = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] header_word,
    input  logic        crc_ok,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  ack_code,
    output logic [1:0]  action,
    output logic [15:0] write_offset,
    output logic [16:0] deliver_length,
    output logic        to_link_layer,
    output logic [2:0]  event_code,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    lprc_pkg::cfg_t    cfg_reg;
    lprc_pkg::state_t  state_reg;
    lprc_pkg::state_t  state_next;
    lprc_pkg::result_t res_reg;
    lprc_pkg::result_t res_next;

    logic        s1_valid_reg;
    logic [15:0] s1_header_reg;
    logic        s1_crc_reg;
    logic        out_valid_reg;
    logic        out_ready;
    logic        s1_load;
    logic        s2_load;

    assign out_ready = ~out_valid_reg | ~out_stall;
    assign s2_load   = s1_valid_reg & out_ready;
    assign in_stall  = s1_valid_reg & ~out_ready;
    assign s1_load   = in_valid & ~in_stall;

    lprc_decide #(
        .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
    ) u_decide (
        .header (s1_header_reg),
        .crc    (s1_crc_reg),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .res    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.version <= '0;
            cfg_reg.ack_en  <= 1'b0;
            cfg_reg.payload <= lprc_pkg::PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lprc_pkg::CFG_VERSION: cfg_reg.version <= cfg_data[7:0];
                lprc_pkg::CFG_ACK_EN:  cfg_reg.ack_en  <= cfg_data[0];
                lprc_pkg::CFG_PAYLOAD: cfg_reg.payload <= cfg_data;
                default:               cfg_reg         <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s2_load)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_header_reg <= header_word;
            s1_crc_reg    <= crc_ok;
        end
        if (s2_load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ack_code       = res_reg.ack;
    assign action         = res_reg.act;
    assign write_offset   = res_reg.offset;
    assign deliver_length = res_reg.length;
    assign to_link_layer  = res_reg.link;
    assign event_code     = res_reg.ev;

    a_act_needs_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.act != lprc_pkg::ACT_NONE
        |-> res_reg.ack == lprc_pkg::ACK_REQUIRED)
        else $error("buffer action on a packet that is not acknowledged");

    a_len_only_on_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.act == lprc_pkg::ACT_NONE
                          || res_reg.act == lprc_pkg::ACT_APPEND)
        |-> res_reg.length == '0)
        else $error("deliver length without a delivery");

    a_error_events: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.ack == lprc_pkg::ACK_FAULT
        |-> (res_reg.ev == lprc_pkg::EV_CRC || res_reg.ev == lprc_pkg::EV_GARBAGE))
        else $error("error acknowledge with a non-error event");

    a_deliver_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load && res_next.act == lprc_pkg::ACT_DELIVER_DG
        |=> state_reg.fill == '0)
        else $error("fill offset kept after datagram delivery");

endmodule
